### design/capesc_pkg.sv
package capesc_pkg;

  localparam logic [7:0] ChNul       = 8'h00;
  localparam logic [7:0] ChCaret     = 8'h5E;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChColon     = 8'h3A;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChNine      = 8'h39;
  localparam logic [7:0] CtrlMask    = 8'h1F;

  localparam int OctW = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_string;
    logic       last;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } esc_t;

  // backslash escape letters
  function automatic esc_t esc_lookup(input logic [7:0] c);
    esc_t r;
    r.hit = 1'b1;
    case (c)
      8'h45:   r.value = 8'h1B; // E
      8'h5E:   r.value = 8'h5E; // ^
      8'h5C:   r.value = 8'h5C; // backslash
      8'h3A:   r.value = 8'h3A; // :
      8'h6E:   r.value = 8'h0A; // n
      8'h72:   r.value = 8'h0D; // r
      8'h74:   r.value = 8'h09; // t
      8'h62:   r.value = 8'h08; // b
      8'h66:   r.value = 8'h0C; // f
      default: begin
        r.hit   = 1'b0;
        r.value = c;
      end
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

endpackage

### design/capesc_decode.sv
module capesc_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          ch,
  output logic [1:0]          count,
  output capesc_pkg::result_t res_a,
  output capesc_pkg::result_t res_b
);
  import capesc_pkg::*;

  typedef enum logic [1:0] {
    NORMAL,
    CARET,
    BSLASH,
    OCTAL
  } mode_t;

  mode_t            mode, mode_next;
  logic [OctW-1:0]  octal_value, octal_value_next;
  logic [1:0]       octal_digits, octal_digits_next;

  // fresh-character decode in normal mode
  logic       p_emit;
  logic       p_eos;
  mode_t      p_mode;

  esc_t            esc;
  logic [OctW-1:0] digit_val;
  logic [OctW-1:0] shifted;
  logic [1:0]      digits_inc;

  always_comb begin
    p_emit = 1'b1;
    p_eos  = 1'b0;
    p_mode = NORMAL;
    if (ch == ChNul || ch == ChColon) begin
      p_eos = 1'b1;
    end else if (ch == ChCaret) begin
      p_emit = 1'b0;
      p_mode = CARET;
    end else if (ch == ChBackslash) begin
      p_emit = 1'b0;
      p_mode = BSLASH;
    end
  end

  assign esc        = esc_lookup(ch);
  assign digit_val  = {{(OctW-4){1'b0}}, ch[3:0]};
  assign shifted    = {octal_value[OctW-4:0], 3'b000} | digit_val;
  assign digits_inc = octal_digits + 2'd1;

  always_comb begin
    mode_next         = mode;
    octal_value_next  = octal_value;
    octal_digits_next = octal_digits;
    count             = 2'd0;
    res_a             = '0;
    res_b             = '0;
    case (mode)
      CARET: begin
        mode_next = NORMAL;
        count     = 2'd1;
        if (ch == ChNul) begin
          res_a.end_of_string = 1'b1;
        end else begin
          res_a.out_byte = ch & CtrlMask;
        end
      end
      BSLASH: begin
        mode_next = NORMAL;
        if (ch == ChNul) begin
          count               = 2'd1;
          res_a.end_of_string = 1'b1;
        end else if (esc.hit) begin
          count          = 2'd1;
          res_a.out_byte = esc.value;
        end else if (is_digit(ch)) begin
          mode_next         = OCTAL;
          octal_value_next  = digit_val;
          octal_digits_next = 2'd1;
        end else begin
          count          = 2'd1;
          res_a.out_byte = ch;
        end
      end
      OCTAL: begin
        if (is_digit(ch)) begin
          if (digits_inc == 2'd3 || digits_inc == 2'd0) begin
            count             = 2'd1;
            res_a.out_byte    = shifted[7:0];
            octal_value_next  = '0;
            octal_digits_next = 2'd0;
            mode_next         = NORMAL;
          end else begin
            octal_value_next  = shifted;
            octal_digits_next = digits_inc;
          end
        end else begin
          // short octal: flush the value, then the character starts afresh
          res_a.out_byte      = octal_value[7:0];
          octal_value_next    = '0;
          octal_digits_next   = 2'd0;
          mode_next           = p_mode;
          res_b.out_byte      = p_eos ? ChNul : ch;
          res_b.end_of_string = p_eos;
          count               = p_emit ? 2'd2 : 2'd1;
        end
      end
      default: begin
        mode_next           = p_mode;
        res_a.out_byte      = p_eos ? ChNul : ch;
        res_a.end_of_string = p_eos;
        count               = p_emit ? 2'd1 : 2'd0;
      end
    endcase
    res_a.last = (count == 2'd1);
    res_b.last = (count == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= NORMAL;
      octal_value  <= '0;
      octal_digits <= 2'd0;
    end else if (take) begin
      mode         <= mode_next;
      octal_value  <= octal_value_next;
      octal_digits <= octal_digits_next;
    end
  end

endmodule

### design/capability_escape_decoder_top.sv
// channel   signals                          direction
// ch        ch_valid, ch_stall, ch           in: raw string characters
// res       res_valid, res_stall, out_byte,  out: decoded bytes
//           end_of_string, last
//
// one character per cycle while ch_stall is low; a character enters an input
// register, is decoded from there by the escape logic and its zero to two
// results go into a four-entry result queue, which drains one beat per cycle
// while res_stall is low; a character with two results gives two output beats
// ch_stall rises only while the queue holds more than two results
// synchronous reset clears the escape state, input valid and queue pointers
module capability_escape_decoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       ch_valid,
  output logic       ch_stall,
  input  logic [7:0] ch,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       end_of_string,
  output logic       last
);
  import capesc_pkg::*;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);

  logic [7:0]      ch_q;
  logic            q_valid;
  logic            take;
  logic [1:0]      n_res;
  result_t         res_a, res_b;

  result_t         queue [QDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   fill, fill_next;
  logic            pop;

  // room for two results before decoding the held character
  assign take     = q_valid && (fill <= (PtrW+1)'(QDepth - 2));
  assign ch_stall = q_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!ch_stall) begin
      q_valid <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!ch_stall && ch_valid) begin
      ch_q <= ch;
    end
  end

  capesc_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .ch    (ch_q),
    .count (n_res),
    .res_a (res_a),
    .res_b (res_b)
  );

  assign res_valid     = (fill != '0);
  assign pop           = res_valid && !res_stall;
  assign out_byte      = queue[rd_ptr].out_byte;
  assign end_of_string = queue[rd_ptr].end_of_string;
  assign last          = queue[rd_ptr].last;

  always_comb begin
    fill_next = fill - (PtrW+1)'(pop);
    if (take) begin
      fill_next = fill_next + (PtrW+1)'(n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      fill <= fill_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (take) begin
        wr_ptr <= wr_ptr + PtrW'(n_res);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && n_res != 2'd0) begin
      queue[wr_ptr] <= res_a;
    end
    if (take && n_res == 2'd2) begin
      queue[wr_ptr + PtrW'(1)] <= res_b;
    end
  end

endmodule

### design/capesc_checker.sv
module capesc_checker (
  input logic       clk,
  input logic       rst,
  input logic       ch_valid,
  input logic       ch_stall,
  input logic [7:0] ch,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_byte,
  input logic       end_of_string,
  input logic       last
);

  // nothing queued or held right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid && !ch_stall)
    else $error("result or stall present after reset");

  // a stalled character beat stays put
  a_ch_hold: assert property (@(posedge clk) disable iff (rst)
    ch_valid && ch_stall |=> ch_valid && $stable(ch))
    else $error("stalled character beat changed");

  // the end marker is a NUL and closes the input's results
  a_end_nul: assert property (@(posedge clk) disable iff (rst)
    res_valid && end_of_string |-> out_byte == 8'h00 && last)
    else $error("end of string beat is not a final NUL");

  // a non-final beat comes only from a flushed octal value, never the end
  a_first_not_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> !end_of_string)
    else $error("end of string beat not marked last");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(out_byte)
      && $stable(end_of_string) && $stable(last))
    else $error("stalled result beat changed");

endmodule

bind capability_escape_decoder_top capesc_checker u_capesc_checker (
  .clk           (clk),
  .rst           (rst),
  .ch_valid      (ch_valid),
  .ch_stall      (ch_stall),
  .ch            (ch),
  .res_valid     (res_valid),
  .res_stall     (res_stall),
  .out_byte      (out_byte),
  .end_of_string (end_of_string),
  .last          (last)
);
